>>> rtl/core/lfs_pkg.sv
// Shared types and constants of the four-sensor line-follow steering block.
// No dependencies; used by every module under rtl/core.
package lfs_pkg;

    localparam int LFS_QUEUE_DEPTH = 4;

    localparam int LFS_SUM_LIMIT  = 100;
    localparam int LFS_SHARP_ERR  = 13;
    localparam int LFS_EDGE_ERR   = 9;
    localparam int LFS_SPEED_MAX  = 1000;

    localparam logic [9:0]  LFS_RST_BASE_SPEED = 10'd300;
    localparam logic [10:0] LFS_RST_PROP_GAIN  = 11'd450;
    localparam logic [7:0]  LFS_RST_INTEG_GAIN = 8'd0;
    localparam logic [10:0] LFS_RST_DERIV_GAIN = 11'd0;
    localparam logic [7:0]  LFS_RST_PERIOD     = 8'd10;
    localparam logic [9:0]  LFS_RST_SHARP_HOLD = 10'd80;
    localparam logic [9:0]  LFS_RST_EDGE_HOLD  = 10'd10;
    localparam logic [7:0]  LFS_RST_LOST_LIMIT = 8'd20;

    localparam int LFS_IN_DATA_W  = 40;
    localparam int LFS_OUT_DATA_W = 40;

    typedef enum logic [2:0] {
        CFG_BASE_SPEED  = 3'd0,
        CFG_PROP_GAIN   = 3'd1,
        CFG_INTEG_GAIN  = 3'd2,
        CFG_DERIV_GAIN  = 3'd3,
        CFG_PERIOD      = 3'd4,
        CFG_SHARP_HOLD  = 3'd5,
        CFG_EDGE_HOLD   = 3'd6,
        CFG_LOST_LIMIT  = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [9:0]  base_speed;
        logic [10:0] prop_gain;
        logic [7:0]  integ_gain;
        logic [10:0] deriv_gain;
        logic [7:0]  update_period_ms;
        logic [9:0]  sharp_hold_ms;
        logic [9:0]  edge_hold_ms;
        logic [7:0]  lost_limit;
    } cfg_t;

    // one classified update, front to back
    typedef struct packed {
        logic               line_lost;
        logic [3:0]         sensor_pattern;
        logic [2:0]         black_count;
        logic signed [4:0]  err;
        logic signed [7:0]  integ;
        logic signed [5:0]  err_delta;
    } q_word_t;

endpackage

>>> rtl/core/lfs_front.sv
// Front end: update-period gate, sensor decode, hold timer, lost-line count
// and error/integral state. Depends on lfs_pkg.
module lfs_front
    import lfs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] time_ms,
    input  logic        outer_left,
    input  logic        inner_left,
    input  logic        inner_right,
    input  logic        outer_right,
    input  logic        q_space,
    output logic        push,
    output q_word_t     push_word
);

    logic [31:0]       last_reg, last_next;
    logic [31:0]       hold_reg, hold_next;
    logic [7:0]        white_reg, white_next;
    logic signed [4:0] err_reg, err_next;
    logic signed [4:0] prev_reg;
    logic signed [7:0] integ_reg, integ_next;

    logic        accept;
    logic        pass;
    logic [31:0] gap;
    logic [31:0] hold_gap;
    logic        ol, il, ir, orr;
    logic [2:0]  black;
    logic [7:0]  white_inc;
    logic        lost;
    logic signed [8:0] integ_sum;

    assign in_ready = q_space;
    assign accept   = in_valid && in_ready;

    assign gap  = time_ms - last_reg;
    assign pass = (last_reg == 32'd0) || (gap >= {24'd0, cfg.update_period_ms});

    // sensor level 0 is black
    assign ol  = ~outer_left;
    assign il  = ~inner_left;
    assign ir  = ~inner_right;
    assign orr = ~outer_right;
    assign black = 3'(ol) + 3'(il) + 3'(ir) + 3'(orr);

    assign white_inc = (white_reg < cfg.lost_limit) ? white_reg + 8'd1 : white_reg;
    assign lost      = (black == 3'd0) && (white_inc >= cfg.lost_limit);
    assign white_next = (black == 3'd0) ? white_inc : 8'd0;

    assign hold_gap = time_ms - hold_reg;

    always_comb
    begin
        err_next  = err_reg;
        hold_next = hold_reg;
        priority if (ol && il && ir && orr)
        begin
            err_next  = 5'sd0;
            hold_next = time_ms;
        end
        else if ((ol || il) && orr)
        begin
            err_next  = 5'(LFS_SHARP_ERR);
            hold_next = time_ms + {22'd0, cfg.sharp_hold_ms};
        end
        else if (ol && (ir || orr))
        begin
            err_next  = -5'(LFS_SHARP_ERR);
            hold_next = time_ms + {22'd0, cfg.sharp_hold_ms};
        end
        else if (hold_gap[31])
        begin
            err_next = err_reg;     // hold still running
        end
        else if (ol)
        begin
            err_next  = -5'(LFS_EDGE_ERR);
            hold_next = time_ms + {22'd0, cfg.edge_hold_ms};
        end
        else if (orr)
        begin
            err_next  = 5'(LFS_EDGE_ERR);
            hold_next = time_ms + {22'd0, cfg.edge_hold_ms};
        end
        else if (il && !ir)
        begin
            err_next = -5'sd1;
        end
        else if (!il && ir)
        begin
            err_next = 5'sd1;
        end
        else if (il && ir)
        begin
            err_next = 5'sd0;
        end
        else
        begin
            err_next = err_reg;     // all white keeps the error
        end
    end

    assign integ_sum = {integ_reg[7], integ_reg} + {{4{err_next[4]}}, err_next};

    always_comb
    begin
        priority if (integ_sum > 9'(LFS_SUM_LIMIT))
            integ_next = 8'(LFS_SUM_LIMIT);
        else if (integ_sum < -9'(LFS_SUM_LIMIT))
            integ_next = -8'(LFS_SUM_LIMIT);
        else
            integ_next = integ_sum[7:0];
    end

    assign last_next = time_ms;
    assign push      = accept && pass;

    always_comb
    begin
        push_word.line_lost      = lost;
        push_word.sensor_pattern = {inner_left, outer_left, inner_right, outer_right};
        push_word.black_count    = black;
        push_word.err            = err_next;
        push_word.integ          = integ_next;
        push_word.err_delta      = {err_next[4], err_next} - {prev_reg[4], prev_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg  <= '0;
            hold_reg  <= '0;
            white_reg <= '0;
            err_reg   <= '0;
            prev_reg  <= '0;
            integ_reg <= '0;
        end
        else if (push)
        begin
            last_reg  <= last_next;
            white_reg <= white_next;
            if (!lost)
            begin
                hold_reg  <= hold_next;
                err_reg   <= err_next;
                prev_reg  <= err_next;
                integ_reg <= integ_next;
            end
        end
    end

    a_integ_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        (integ_reg <= 8'(LFS_SUM_LIMIT)) && (integ_reg >= -8'(LFS_SUM_LIMIT)))
        else $error("integral outside clamp");

    a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
        (err_reg <= 5'(LFS_SHARP_ERR)) && (err_reg >= -5'(LFS_SHARP_ERR)))
        else $error("position error out of range");

    a_lost_keeps_err: assert property (@(posedge clk) disable iff (!rst_n)
        (push && lost) |=> $stable(err_reg) && $stable(integ_reg))
        else $error("lost-line update changed the error state");

endmodule

>>> rtl/core/lfs_queue.sv
// Small FIFO of classified updates between front and back end.
// Depends on lfs_pkg for the word type.
module lfs_queue
    import lfs_pkg::*;
#(
    parameter int DEPTH = LFS_QUEUE_DEPTH
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  q_word_t push_word,
    output logic    space,
    output logic    pop_valid,
    input  logic    pop,
    output q_word_t pop_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    q_word_t         mem_reg [DEPTH];
    logic [PW-1:0]   wr_reg, wr_next;
    logic [PW-1:0]   rd_reg, rd_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_pop;

    assign space     = (count_reg != CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_word  = mem_reg[rd_reg];
    assign do_pop    = pop && pop_valid;

    assign wr_next = (wr_reg == PW'(DEPTH - 1)) ? '0 : wr_reg + PW'(1);
    assign rd_next = (rd_reg == PW'(DEPTH - 1)) ? '0 : rd_reg + PW'(1);

    always_comb
    begin
        unique case ({push, do_pop})
            2'b10:   count_next = count_reg + CW'(1);
            2'b01:   count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
                wr_reg <= wr_next;
            if (do_pop)
                rd_reg <= rd_next;
            count_reg <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> space)
        else $error("write into full queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");

endmodule

>>> rtl/core/lfs_back.sv
// Back end: PID products in one stage, sum and 16-bit saturation into the
// output register. Depends on lfs_pkg.
module lfs_back
    import lfs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  cfg_t                      cfg,
    input  logic                      q_valid,
    output logic                      q_pop,
    input  q_word_t                   q_word,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [LFS_OUT_DATA_W-1:0] m_tdata,
    output logic                      m_tuser
);

    logic signed [16:0] err_x, integ_x, delta_x;
    logic signed [16:0] pg_x, ig_x, dg_x;
    logic signed [16:0] prod_p, prod_i, prod_d;

    logic               v1_reg;
    logic               lost1_reg;
    logic [3:0]         pat1_reg;
    logic [2:0]         blk1_reg;
    logic signed [16:0] p1_reg, i1_reg, d1_reg;

    logic               out_v_reg;
    logic [9:0]         speed_reg;
    logic [15:0]        turn_reg, turn_next;
    logic [3:0]         pat_reg;
    logic [2:0]         blk_reg;
    logic               lost_reg;

    logic               adv2;
    logic               adv1;
    logic signed [18:0] sum;

    assign adv2  = !out_v_reg || m_tready;
    assign adv1  = !v1_reg || adv2;
    assign q_pop = adv1;

    assign err_x   = {{12{q_word.err[4]}}, q_word.err};
    assign integ_x = {{9{q_word.integ[7]}}, q_word.integ};
    assign delta_x = {{11{q_word.err_delta[5]}}, q_word.err_delta};
    assign pg_x    = {6'd0, cfg.prop_gain};
    assign ig_x    = {9'd0, cfg.integ_gain};
    assign dg_x    = {6'd0, cfg.deriv_gain};

    assign prod_p = err_x * pg_x;
    assign prod_i = integ_x * ig_x;
    assign prod_d = delta_x * dg_x;

    assign sum = {{2{p1_reg[16]}}, p1_reg} + {{2{i1_reg[16]}}, i1_reg}
               + {{2{d1_reg[16]}}, d1_reg};

    always_comb
    begin
        priority if (lost1_reg)
            turn_next = 16'd0;
        else if (sum > 19'sd32767)
            turn_next = 16'h7FFF;
        else if (sum < -19'sd32768)
            turn_next = 16'h8000;
        else
            turn_next = sum[15:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
                v1_reg <= q_valid;
            if (adv2)
                out_v_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            lost1_reg <= q_word.line_lost;
            pat1_reg  <= q_word.sensor_pattern;
            blk1_reg  <= q_word.black_count;
            p1_reg    <= prod_p;
            i1_reg    <= prod_i;
            d1_reg    <= prod_d;
        end
        if (adv2)
        begin
            speed_reg <= lost1_reg ? 10'd0 : cfg.base_speed;
            turn_reg  <= turn_next;
            pat_reg   <= pat1_reg;
            blk_reg   <= blk1_reg;
            lost_reg  <= lost1_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tuser  = lost_reg;
    assign m_tdata  = {7'd0, blk_reg, pat_reg, turn_reg, speed_reg};

    a_stop_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && lost_reg) |-> (speed_reg == 10'd0) && (turn_reg == 16'd0))
        else $error("stop word carries nonzero drive");

endmodule

>>> rtl/core/four_sensor_line_follow_steering.sv
// Top level of the four-sensor line-follow steering block: configuration
// registers, front end, queue and PID back end. Depends on lfs_pkg.
//
//  channel  | dir | handshake               | payload
//  ---------+-----+-------------------------+---------------------------------------
//  s_*      | in  | s_tvalid / s_tready     | tdata: time_ms, outer_left, inner_left,
//           |     |                         |        inner_right, outer_right
//  m_*      | out | m_tvalid / m_tready     | tdata: drive_speed, drive_turn,
//           |     |                         |        sensor_pattern, black_count
//           |     |                         | tuser: line_lost
//  cfg_*    | in  | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One input word per cycle while the queue has space; an update word is decoded
// in the front, then registered in the queue, the product stage and the output register.
// Words inside the update period are taken and dropped, giving no output.
// The queue decouples the front: s_tready drops only when it is full.
// Reset clears the decode state and loads register defaults; no clearing pass.
module four_sensor_line_follow_steering
    import lfs_pkg::*;
#(
    parameter int QUEUE_DEPTH = LFS_QUEUE_DEPTH
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // [31:0] time_ms, [32] outer_left, [33] inner_left, [34] inner_right,
    // [35] outer_right, [39:36] zero
    input  logic [LFS_IN_DATA_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // [9:0] drive_speed, [25:10] drive_turn, [29:26] sensor_pattern,
    // [32:30] black_count, [39:33] zero
    output logic [LFS_OUT_DATA_W-1:0] m_tdata,
    // [0] line_lost
    output logic                      m_tuser,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [10:0]               cfg_data
);

    cfg_t       cfg_reg;
    logic [9:0] speed_wr;

    logic    q_space;
    logic    push;
    q_word_t push_word;
    logic    q_valid;
    logic    q_pop;
    q_word_t q_word;

    assign cfg_ready = 1'b1;
    assign speed_wr  = (cfg_data[9:0] > 10'(LFS_SPEED_MAX)) ? 10'(LFS_SPEED_MAX)
                                                             : cfg_data[9:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.base_speed       <= LFS_RST_BASE_SPEED;
            cfg_reg.prop_gain        <= LFS_RST_PROP_GAIN;
            cfg_reg.integ_gain       <= LFS_RST_INTEG_GAIN;
            cfg_reg.deriv_gain       <= LFS_RST_DERIV_GAIN;
            cfg_reg.update_period_ms <= LFS_RST_PERIOD;
            cfg_reg.sharp_hold_ms    <= LFS_RST_SHARP_HOLD;
            cfg_reg.edge_hold_ms     <= LFS_RST_EDGE_HOLD;
            cfg_reg.lost_limit       <= LFS_RST_LOST_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_BASE_SPEED: cfg_reg.base_speed       <= speed_wr;
                CFG_PROP_GAIN:  cfg_reg.prop_gain        <= cfg_data;
                CFG_INTEG_GAIN: cfg_reg.integ_gain       <= cfg_data[7:0];
                CFG_DERIV_GAIN: cfg_reg.deriv_gain       <= cfg_data;
                CFG_PERIOD:     cfg_reg.update_period_ms <= cfg_data[7:0];
                CFG_SHARP_HOLD: cfg_reg.sharp_hold_ms    <= cfg_data[9:0];
                CFG_EDGE_HOLD:  cfg_reg.edge_hold_ms     <= cfg_data[9:0];
                CFG_LOST_LIMIT: cfg_reg.lost_limit       <= cfg_data[7:0];
                default:        cfg_reg.lost_limit       <= cfg_reg.lost_limit;
            endcase
        end
    end

    lfs_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .time_ms     (s_tdata[31:0]),
        .outer_left  (s_tdata[32]),
        .inner_left  (s_tdata[33]),
        .inner_right (s_tdata[34]),
        .outer_right (s_tdata[35]),
        .q_space     (q_space),
        .push        (push),
        .push_word   (push_word)
    );

    lfs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .space     (q_space),
        .pop_valid (q_valid),
        .pop       (q_pop),
        .pop_word  (q_word)
    );

    lfs_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_word   (q_word),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

>>> test/testbench.sv
// Testbench for four_sensor_line_follow_steering: a directed table, then random
// phases with fresh register settings, checked by a behavioral predictor or typed table words.
// Depends on lfs_pkg and the RTL top level only.
module testbench;

    import lfs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 94;

    typedef struct packed {
        logic [9:0]         speed;
        logic signed [15:0] turn;
        logic [3:0]         pattern;
        logic [2:0]         nblack;
        logic               lost;
    } steer_word_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    // lvl is {outer_right, inner_right, inner_left, outer_left}, 0 = black
    typedef struct packed {
        row_kind_t   kind;
        cfg_idx_t    reg_idx;
        logic [10:0] reg_val;
        logic [31:0] t;
        logic [3:0]  lvl;
        logic        typed;
        steer_word_t want;
    } row_t;

    localparam steer_word_t NO_WANT = '0;
    localparam steer_word_t WHITE_STOP = '{10'd0, 16'sd0, 4'd15, 3'd0, 1'b1};

    localparam row_t DIR_ROWS [37] = '{
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd100, 4'b1111, 1'b1,
          '{10'd300, 16'sd0, 4'd15, 3'd0, 1'b0}},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd105, 4'b0000, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd110, 4'b0000, 1'b1,
          '{10'd300, 16'sd0, 4'd0, 3'd4, 1'b0}},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd120, 4'b1110, 1'b1,
          '{10'd300, -16'sd4050, 4'd11, 3'd1, 1'b0}},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd125, 4'b1110, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd130, 4'b1011, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd140, 4'b0110, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd150, 4'b1101, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd230, 4'b1010, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd240, 4'b0111, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd320, 4'b1001, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd330, 4'b0111, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd340, 4'b1101, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1, 4'b1111, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'hFFFF_FFF8, 4'b1110, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd2, 4'b1101, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_LOST_LIMIT, 11'd2, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_PERIOD, 11'd0, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1000, 4'b1111, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1000, 4'b1111, 1'b1, WHITE_STOP},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1000, 4'b1111, 1'b1, WHITE_STOP},
        '{ROW_CFG, CFG_LOST_LIMIT, 11'd0, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1001, 4'b0000, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1002, 4'b1111, 1'b1, WHITE_STOP},
        '{ROW_CFG, CFG_BASE_SPEED, 11'd1023, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_PROP_GAIN, 11'd2047, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_INTEG_GAIN, 11'd255, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_DERIV_GAIN, 11'd2047, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_SHARP_HOLD, 11'd0, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_EDGE_HOLD, 11'd1023, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_LOST_LIMIT, 11'd255, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_CFG, CFG_PERIOD, 11'd1, 32'd0, 4'b0000, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1010, 4'b0110, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1011, 4'b1010, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1012, 4'b1110, 1'b0, NO_WANT},
        '{ROW_ITEM, CFG_BASE_SPEED, 11'd0, 32'd1013, 4'b0111, 1'b0, NO_WANT}
    };

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [LFS_IN_DATA_W-1:0]  s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [LFS_OUT_DATA_W-1:0] m_tdata;
    logic                      m_tuser;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [2:0]                cfg_index;
    logic [10:0]               cfg_data;

    // predictor copy of the registers and the tracking state
    cfg_t        shadow;
    logic [31:0] last_upd_ms;
    logic [31:0] hold_until_ms;
    logic [7:0]  white_run;
    int          pos_err;
    int          prev_err;
    int          err_sum;

    steer_word_t pending_steer[$];
    steer_word_t got_word;
    steer_word_t want_word;
    int          fails;
    int          cycles;
    bit          no_idle;

    four_sensor_line_follow_steering dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic steer_predict(input logic [31:0] now, input logic [3:0] lvl,
                                 output bit made, output steer_word_t w);
        logic [31:0] since_upd;
        logic [31:0] since_hold;
        logic        blk_ol;
        logic        blk_il;
        logic        blk_ir;
        logic        blk_or;
        logic [3:0]  pattern;
        logic [2:0]  nblack;
        int          turn;
        made = 1'b0;
        w = '0;
        since_upd = now - last_upd_ms;
        if (last_upd_ms != 32'd0 && since_upd < 32'(shadow.update_period_ms))
            return;
        last_upd_ms = now;
        made = 1'b1;
        blk_ol = !lvl[0];
        blk_il = !lvl[1];
        blk_ir = !lvl[2];
        blk_or = !lvl[3];
        pattern = {lvl[1], lvl[0], lvl[2], lvl[3]};
        nblack = {2'b0, blk_ol} + {2'b0, blk_il} + {2'b0, blk_ir} + {2'b0, blk_or};
        if (nblack == 3'd0)
        begin
            if (white_run < shadow.lost_limit)
                white_run = white_run + 8'd1;
            if (white_run >= shadow.lost_limit)
            begin
                w = '{10'd0, 16'sd0, pattern, nblack, 1'b1};
                return;
            end
        end
        else
            white_run = 8'd0;

        since_hold = now - hold_until_ms;
        if (blk_ol && blk_il && blk_ir && blk_or)
        begin
            pos_err = 0;
            hold_until_ms = now;
        end
        else if ((blk_ol || blk_il) && blk_or)
        begin
            pos_err = LFS_SHARP_ERR;
            hold_until_ms = now + 32'(shadow.sharp_hold_ms);
        end
        else if (blk_ol && (blk_ir || blk_or))
        begin
            pos_err = -LFS_SHARP_ERR;
            hold_until_ms = now + 32'(shadow.sharp_hold_ms);
        end
        else if (since_hold[31])
        begin
            // hold still running: error stays
        end
        else if (blk_ol)
        begin
            pos_err = -LFS_EDGE_ERR;
            hold_until_ms = now + 32'(shadow.edge_hold_ms);
        end
        else if (blk_or)
        begin
            pos_err = LFS_EDGE_ERR;
            hold_until_ms = now + 32'(shadow.edge_hold_ms);
        end
        else if (blk_il && !blk_ir)
            pos_err = -1;
        else if (!blk_il && blk_ir)
            pos_err = 1;
        else if (blk_il && blk_ir)
            pos_err = 0;

        err_sum = err_sum + pos_err;
        if (err_sum > LFS_SUM_LIMIT)
            err_sum = LFS_SUM_LIMIT;
        if (err_sum < -LFS_SUM_LIMIT)
            err_sum = -LFS_SUM_LIMIT;
        turn = pos_err * int'(shadow.prop_gain) + err_sum * int'(shadow.integ_gain)
             + (pos_err - prev_err) * int'(shadow.deriv_gain);
        prev_err = pos_err;
        if (turn > 32767)
            turn = 32767;
        if (turn < -32768)
            turn = -32768;
        w = '{shadow.base_speed, 16'(turn), pattern, nblack, 1'b0};
    endtask

    // drive one reading; returns right after the posedge that took it
    task automatic send_reading(input logic [31:0] t, input logic [3:0] lvl,
                                input bit typed, input steer_word_t want);
        bit          made;
        steer_word_t w;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, lvl, t};
        do
            @(posedge clk);
        while (!s_tready);
        steer_predict(t, lvl, made, w);
        if (typed)
            pending_steer.push_back(want);
        else if (made)
            pending_steer.push_back(w);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [10:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_BASE_SPEED:
                shadow.base_speed = (int'(val[9:0]) > LFS_SPEED_MAX) ?
                                    10'(LFS_SPEED_MAX) : val[9:0];
            CFG_PROP_GAIN:  shadow.prop_gain = val;
            CFG_INTEG_GAIN: shadow.integ_gain = val[7:0];
            CFG_DERIV_GAIN: shadow.deriv_gain = val;
            CFG_PERIOD:     shadow.update_period_ms = val[7:0];
            CFG_SHARP_HOLD: shadow.sharp_hold_ms = val[9:0];
            CFG_EDGE_HOLD:  shadow.edge_hold_ms = val[9:0];
            CFG_LOST_LIMIT: shadow.lost_limit = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // park the sender and let the pipeline drain, dropped words included
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_steer.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_word = '{m_tdata[9:0], m_tdata[25:10], m_tdata[29:26], m_tdata[32:30],
                         m_tuser};
            if (pending_steer.size() == 0)
            begin
                fails <= fails + 1;
                if (fails < 10)
                    $display("unexpected word: speed %0d turn %0d pattern %h black %0d lost %b",
                             got_word.speed, $signed(got_word.turn), got_word.pattern,
                             got_word.nblack, got_word.lost);
            end
            else
            begin
                want_word = pending_steer.pop_front();
                if (got_word.speed !== want_word.speed || got_word.turn !== want_word.turn
                    || got_word.pattern !== want_word.pattern
                    || got_word.nblack !== want_word.nblack
                    || got_word.lost !== want_word.lost)
                begin
                    fails <= fails + 1;
                    if (fails < 10)
                        $display({"mismatch (exp/got): speed %0d/%0d turn %0d/%0d ",
                                  "pattern %h/%h black %0d/%0d lost %b/%b"},
                                 want_word.speed, got_word.speed,
                                 $signed(want_word.turn), $signed(got_word.turn),
                                 want_word.pattern, got_word.pattern,
                                 want_word.nblack, got_word.nblack,
                                 want_word.lost, got_word.lost);
                end
            end
        end
    end

    // result side: ready with random stall bursts
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!no_idle && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(0, 16)) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        int          k;
        int          ph;
        int          r;
        int          n;
        int          pick;
        int          white_left;
        int          lo;
        int          hi;
        logic [10:0] mx;
        logic [10:0] val;
        cfg_idx_t    idx;
        logic [31:0] cur_time;
        logic [3:0]  lvl;

        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_BASE_SPEED;
        cfg_data = '0;
        fails = 0;
        cycles = 0;
        no_idle = 1'b0;
        shadow = '{LFS_RST_BASE_SPEED, LFS_RST_PROP_GAIN, LFS_RST_INTEG_GAIN,
                   LFS_RST_DERIV_GAIN, LFS_RST_PERIOD, LFS_RST_SHARP_HOLD,
                   LFS_RST_EDGE_HOLD, LFS_RST_LOST_LIMIT};
        last_upd_ms = '0;
        hold_until_ms = '0;
        white_run = '0;
        pos_err = 0;
        prev_err = 0;
        err_sum = 0;
        cur_time = 32'd5000;
        white_left = 0;

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        for (k = 0; k < $size(DIR_ROWS); k++)
        begin
            if (DIR_ROWS[k].kind == ROW_CFG)
            begin
                settle();
                write_reg(DIR_ROWS[k].reg_idx, DIR_ROWS[k].reg_val);
            end
            else
                send_reading(DIR_ROWS[k].t, DIR_ROWS[k].lvl, DIR_ROWS[k].typed,
                             DIR_ROWS[k].want);
        end

        for (ph = 0; ph < RAND_PHASES; ph++)
        begin
            settle();
            // quiet tail in the last phase, and now and then a quiet phase earlier
            no_idle = (ph == RAND_PHASES - 1) || ($urandom_range(0, 5) == 0);
            for (r = 0; r < 8; r++)
            begin
                idx = cfg_idx_t'(r);
                case (idx)
                    CFG_BASE_SPEED: begin mx = 11'd1023; lo = 0; hi = 1000; end
                    CFG_PROP_GAIN:  begin mx = 11'd2047; lo = 0; hi = 1000; end
                    CFG_INTEG_GAIN: begin mx = 11'd255;  lo = 0; hi = 40;   end
                    CFG_DERIV_GAIN: begin mx = 11'd2047; lo = 0; hi = 1000; end
                    CFG_PERIOD:     begin mx = 11'd255;  lo = 1; hi = 15;   end
                    CFG_SHARP_HOLD: begin mx = 11'd1023; lo = 0; hi = 100;  end
                    CFG_EDGE_HOLD:  begin mx = 11'd1023; lo = 0; hi = 60;   end
                    default:        begin mx = 11'd255;  lo = 1; hi = 6;    end
                endcase
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    val = 11'd0;
                else if (pick == 1)
                    val = mx;
                else
                    val = 11'($urandom_range(lo, hi));
                write_reg(idx, val);
            end

            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if (!no_idle && $urandom_range(0, 7) == 0)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(0, 16)) @(negedge clk);
                end

                pick = $urandom_range(0, 99);
                if (pick < 70)
                    cur_time = cur_time
                             + $urandom_range(0, 2 * int'(shadow.update_period_ms) + 2);
                else if (pick < 80)
                    cur_time = cur_time + $urandom_range(0, 3);
                else if (pick < 88)
                    cur_time = $urandom;
                else if (pick < 92)
                    cur_time = 32'd0;
                else if (pick < 96)
                    cur_time = 32'hFFFF_FFFF - $urandom_range(0, 40);
                else
                    cur_time = cur_time - $urandom_range(1, 50);

                // mostly line-like readings, with runs of white to reach the stop
                if (white_left > 0)
                begin
                    lvl = 4'b1111;
                    white_left--;
                end
                else
                begin
                    pick = $urandom_range(0, 99);
                    if (pick < 8)
                        white_left = $urandom_range(1, int'(shadow.lost_limit) + 3);
                    if (pick < 30)
                        lvl = 4'b1111;
                    else if (pick < 40)
                        lvl = 4'b0000;
                    else
                        lvl = 4'($urandom_range(0, 15));
                end
                send_reading(cur_time, lvl, 1'b0, NO_WANT);
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_steer.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
